@@ src/salc_pkg.sv @@
package salc_pkg;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STORE   = 2'd1;
    localparam logic [1:0] REQ_MODIFY  = 2'd2;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;
    localparam logic [1:0] CFG_UNUSED      = 2'd3;

    localparam logic [30:0] STAMP_MAX = 31'h7fffffff;

    typedef struct packed {
        logic start;
        logic lookup;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

endpackage

@@ src/salc_if.sv @@
interface salc_if #(
    parameter int W = 8
) (
    input logic i_clk
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/set_assoc_lru_cache_sim.sv @@
// Set-associative cache model with LRU replacement. After reset the block clears every
// line before it accepts a word. An access then reads the set from the way RAMs,
// compares and updates, and presents the result word, which waits for as long as the
// output stalls. A load or store makes one access; a modify request makes two accesses
// and two result words. No new request is accepted until the last result word is taken.
// The user must write configuration only while idle; the block does not enforce this.
// Lines survive configuration changes.
module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    salc_if.sink   in_ch,
    salc_if.sink   cfg_ch,
    salc_if.source out_ch
);
    import salc_pkg::*;

    logic [3:0] r_set_bits;
    logic [4:0] r_offset_bits;
    logic [3:0] r_ways;
    logic [ADDR_BITS-1:0] r_addr;
    t_cmd cmd;
    t_status status;
    logic hit, evicted, last, in_ready, out_valid;
    logic [31:0] ht, mt, et;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.data = {hit, evicted, ht, mt, et, last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits <= '0;
            r_offset_bits <= '0;
            r_ways <= 4'd1;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.data[6:5])
                CFG_SET_BITS: r_set_bits <= cfg_ch.data[3:0];
                CFG_OFFSET_BITS: r_offset_bits <= cfg_ch.data[4:0];
                CFG_WAYS: r_ways <= cfg_ch.data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.start) begin
            r_addr <= in_ch.data[ADDR_BITS-1:0];
        end
    end

    salc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_req_type(in_ch.data[65:64]),
        .o_in_ready(in_ready), .i_out_ready(out_ch.ready),
        .o_out_valid(out_valid), .o_last(last), .o_cmd(cmd), .i_status(status)
    );

    salc_datapath #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS),
                    .ADDR_BITS(ADDR_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_address(r_addr),
        .i_set_bits(r_set_bits), .i_offset_bits(r_offset_bits), .i_ways(r_ways),
        .o_hit(hit), .o_evicted(evicted), .o_hit_total(ht),
        .o_miss_total(mt), .o_eviction_total(et)
    );
endmodule

@@ src/salc_ram.sv @@
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ src/salc_datapath.sv @@
module salc_datapath #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_BITS    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  salc_pkg::t_cmd       i_cmd,
    output salc_pkg::t_status    o_status,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [3:0]           i_set_bits,
    input  logic [4:0]           i_offset_bits,
    input  logic [3:0]           i_ways,
    output logic                 o_hit,
    output logic                 o_evicted,
    output logic [31:0]          o_hit_total,
    output logic [31:0]          o_miss_total,
    output logic [31:0]          o_eviction_total
);
    import salc_pkg::*;

    localparam int SETS  = 1 << MAX_SET_BITS;
    localparam int SB    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LW    = 1 + ADDR_BITS + 31;
    localparam int SHW   = $clog2(ADDR_BITS + 1) + 1;

    logic [LW-1:0]   rd [MAX_WAYS];
    logic [SB-1:0]   set_idx;
    logic [ADDR_BITS-1:0] tag;
    logic [30:0]     r_stamp;
    logic [31:0]     r_hits, r_misses, r_evicts;
    logic [3:0]      s_eff;
    logic [4:0]      ways_eff;
    logic [5:0]      b_plus_s;
    logic [ADDR_BITS-1:0] shifted;
    logic [MAX_WAYS-1:0] line_v;
    logic            hit_any;
    logic [WB-1:0]   hit_way, vic_way, sel_way;
    logic [30:0]     vic_stamp;
    logic [30:0]     n_stamp;
    logic            r_clearing;
    logic [SB-1:0]   r_clr_idx;
    logic [SB-1:0]   ram_waddr;
    logic [LW-1:0]   ram_wdata;

    assign s_eff = (i_set_bits > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : i_set_bits;
    assign ways_eff = (i_ways == 4'd0) ? 5'd1 :
                      ((5'(i_ways) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(i_ways));
    assign b_plus_s = 6'(i_offset_bits) + 6'(s_eff);
    assign shifted = (SHW'(i_offset_bits) >= SHW'(ADDR_BITS)) ? '0 : (i_address >> i_offset_bits);
    assign set_idx = SB'(shifted & ((ADDR_BITS'(1) << s_eff) - ADDR_BITS'(1)));
    assign tag = (SHW'(b_plus_s) >= SHW'(ADDR_BITS)) ? '0 : (i_address >> b_plus_s);
    assign n_stamp = (r_stamp == STAMP_MAX) ? r_stamp : r_stamp + 31'd1;

    assign o_status.done = !r_clearing;
    assign ram_waddr = r_clearing ? r_clr_idx : set_idx;
    assign ram_wdata = r_clearing ? '0 : {1'b1, tag, n_stamp};

    for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
        salc_ram #(.WIDTH(LW), .DEPTH(SETS)) u_ram (
            .i_clk  (i_clk),
            .i_we   (r_clearing || (i_cmd.commit && sel_way == WB'(w))),
            .i_waddr(ram_waddr),
            .i_wdata(ram_wdata),
            .i_raddr(set_idx),
            .o_rdata(rd[w])
        );
        assign line_v[w] = rd[w][LW-1];
    end

    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        vic_way = '0;
        vic_stamp = line_v[0] ? rd[0][30:0] : 31'd0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (5'(w) < ways_eff && line_v[w] && rd[w][LW-2:31] == tag) begin
                hit_any = 1'b1;
                hit_way = WB'(w);
            end
        end
        for (int w = 1; w < MAX_WAYS; w++) begin
            if (5'(w) < ways_eff &&
                (line_v[w] ? rd[w][30:0] : 31'd0) < vic_stamp) begin
                vic_way = WB'(w);
                vic_stamp = line_v[w] ? rd[w][30:0] : 31'd0;
            end
        end
        sel_way = hit_any ? hit_way : vic_way;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + SB'(1);
            if (r_clr_idx == SB'(SETS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_hits <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (i_cmd.commit) begin
            r_stamp <= n_stamp;
            o_hit <= hit_any;
            o_evicted <= !hit_any && line_v[vic_way];
            if (hit_any) begin
                r_hits <= (r_hits == '1) ? r_hits : r_hits + 32'd1;
            end else begin
                r_misses <= (r_misses == '1) ? r_misses : r_misses + 32'd1;
                if (line_v[vic_way]) begin
                    r_evicts <= (r_evicts == '1) ? r_evicts : r_evicts + 32'd1;
                end
            end
        end
    end

    assign o_hit_total = r_hits;
    assign o_miss_total = r_misses;
    assign o_eviction_total = r_evicts;
endmodule

@@ src/salc_ctrl.sv @@
module salc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_last,
    output salc_pkg::t_cmd    o_cmd,
    input  salc_pkg::t_status i_status
);
    import salc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_second, n_second;
    logic       r_last, n_last;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.done;
    assign o_out_valid = (r_state == ST_OUT);
    assign o_last = r_last;

    always_comb begin
        n_state = r_state;
        n_second = r_second;
        n_last = r_last;
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_in_ready && i_in_valid && i_req_type != REQ_UNKNOWN) begin
                    n_state = ST_READ;
                    n_second = (i_req_type == REQ_MODIFY);
                    o_cmd.start = 1'b1;
                end
            end
            ST_READ: begin
                o_cmd.lookup = 1'b1;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.commit = 1'b1;
                n_last = !r_second;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    if (r_second) begin
                        n_second = 1'b0;
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_second <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_second <= n_second;
            r_last <= n_last;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.start, o_cmd.lookup, o_cmd.commit}))
        else $error("multiple commands");
    a_commit_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(o_cmd.lookup))
        else $error("commit without lookup");
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.commit))
        else $error("result without commit");
endmodule

@@ verif/salc_checker.sv @@
`timescale 1ns / 1ps

module salc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [65:0]  i_req_data,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [6:0]   i_cfg_data,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [98:0]  i_res_data,
    output int           o_fail_count,
    output int           o_pending
);
    import salc_pkg::*;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
        logic        last;
    } t_access_result;

    localparam int SETS = 256;
    localparam int WAYS = 8;

    logic        line_ok   [SETS*WAYS];
    logic [63:0] line_tag  [SETS*WAYS];
    logic [31:0] line_age  [SETS*WAYS];
    logic [31:0] now_stamp;
    logic [31:0] hits, misses, evictions;
    logic [3:0]  set_bits_reg;
    logic [4:0]  offset_reg;
    logic [3:0]  ways_reg;

    t_access_result results_due[$];

    function automatic logic [31:0] bump(logic [31:0] v, logic [31:0] top);
        return (v < top) ? v + 32'd1 : top;
    endfunction

    task automatic model_access(input logic [63:0] addr, input logic is_last);
        int s;
        int b;
        int nw;
        int base;
        int victim;
        logic [63:0] tag;
        logic [63:0] set_idx;
        t_access_result r;
        s = (set_bits_reg > 8) ? 8 : set_bits_reg;
        b = offset_reg;
        nw = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : ways_reg);
        tag = (b + s >= 64) ? 64'd0 : (addr >> (b + s));
        set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
        base = int'(set_idx[7:0]) * WAYS;
        now_stamp = bump(now_stamp, 32'h7fffffff);
        r = '0;
        for (int w = 0; w < nw; w++) begin
            if (!r.hit && line_ok[base+w] && line_tag[base+w] == tag) begin
                r.hit = 1'b1;
                line_age[base+w] = now_stamp;
            end
        end
        if (r.hit) begin
            hits = bump(hits, 32'hffffffff);
        end else begin
            misses = bump(misses, 32'hffffffff);
            victim = 0;
            for (int w = 1; w < nw; w++) begin
                if (line_age[base+w] < line_age[base+victim]) victim = w;
            end
            if (line_ok[base+victim]) begin
                r.evicted = 1'b1;
                evictions = bump(evictions, 32'hffffffff);
            end
            line_ok[base+victim] = 1'b1;
            line_tag[base+victim] = tag;
            line_age[base+victim] = now_stamp;
        end
        r.hit_total = hits;
        r.miss_total = misses;
        r.eviction_total = evictions;
        r.last = is_last;
        results_due.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_access_result got;
        t_access_result want;
        logic [1:0] rtype;
        if (!i_rst_n) begin
            for (int i = 0; i < SETS*WAYS; i++) begin
                line_ok[i] = 1'b0;
                line_tag[i] = '0;
                line_age[i] = '0;
            end
            now_stamp = '0;
            hits = '0;
            misses = '0;
            evictions = '0;
            set_bits_reg = '0;
            offset_reg = '0;
            ways_reg = 4'd1;
            results_due.delete();
            o_fail_count = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_data[6:5])
                    CFG_SET_BITS:    set_bits_reg = {1'b0, i_cfg_data[2:0]} | {i_cfg_data[3], 3'b0};
                    CFG_OFFSET_BITS: offset_reg = i_cfg_data[4:0];
                    CFG_WAYS:        ways_reg = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                rtype = i_req_data[65:64];
                if (rtype == REQ_LOAD || rtype == REQ_STORE) begin
                    model_access(i_req_data[63:0], 1'b1);
                end else if (rtype == REQ_MODIFY) begin
                    model_access(i_req_data[63:0], 1'b0);
                    model_access(i_req_data[63:0], 1'b1);
                end
            end
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected hit=%b ev=%b h=%0d m=%0d e=%0d last=%b",
                                 $time, want.hit, want.evicted, want.hit_total,
                                 want.miss_total, want.eviction_total, want.last);
                        $display("%0t:          actual hit=%b ev=%b h=%0d m=%0d e=%0d last=%b",
                                 $time, got.hit, got.evicted, got.hit_total,
                                 got.miss_total, got.eviction_total, got.last);
                        o_fail_count++;
                    end
                end
            end
            o_pending = results_due.size();
        end
    end
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import salc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   cur_set_bits;
    int   cur_offset;

    salc_if #(.W(66)) req_if (.i_clk(i_clk));
    salc_if #(.W(7))  cfg_if (.i_clk(i_clk));
    salc_if #(.W(99)) res_if (.i_clk(i_clk));

    set_assoc_lru_cache_sim dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (req_if),
        .cfg_ch (cfg_if),
        .out_ch (res_if)
    );

    salc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req_data  (req_if.data),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_data  (cfg_if.data),
        .i_res_valid (res_if.valid),
        .i_res_ready (res_if.ready),
        .i_res_data  (res_if.data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[set_assoc_lru_cache_sim] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= {idx, value};
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_req(input logic [1:0] rtype, input logic [63:0] addr);
        if ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= {rtype, addr};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic end_burst();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] make_addr(input logic [63:0] tag, input int set_idx);
        logic [63:0] offs;
        offs = {$urandom, $urandom} & ((64'd1 << cur_offset) - 64'd1);
        return (tag << (cur_offset + cur_set_bits)) | (64'(set_idx) << cur_offset) | offs;
    endfunction

    function automatic logic [1:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 3) return REQ_UNKNOWN;
        if (r < 40) return REQ_LOAD;
        if (r < 70) return REQ_STORE;
        return REQ_MODIFY;
    endfunction

    initial begin
        int cfg_sets [8] = '{0, 8, 2, 15, 3, 1, 8, 4};
        int cfg_offs [8] = '{0, 31, 4, 0, 5, 31, 6, 2};
        int cfg_ways [8] = '{1, 8, 4, 15, 0, 2, 8, 3};
        logic [63:0] addr;
        int n_sets;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_set_bits = 0;
        cur_offset = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(REQ_LOAD, 64'd0);
        send_req(REQ_LOAD, 64'd0);
        send_req(REQ_STORE, 64'hffff_ffff_ffff_ffff);
        send_req(REQ_MODIFY, 64'hffff_ffff_ffff_ffff);
        send_req(REQ_UNKNOWN, 64'h1234);
        send_req(REQ_MODIFY, 64'h8000_0000_0000_0000);
        send_req(REQ_LOAD, 64'h5555_5555_5555_5555);
        send_req(REQ_STORE, 64'haaaa_aaaa_aaaa_aaaa);
        send_req(REQ_LOAD, 64'd0);
        end_burst();
        drain();
        write_reg(CFG_UNUSED, 5'd7);
        write_reg(CFG_WAYS, 5'd2);
        write_reg(CFG_SET_BITS, 5'd1);
        cur_set_bits = 1;
        send_req(REQ_LOAD, 64'h0);
        send_req(REQ_LOAD, 64'h2);
        send_req(REQ_LOAD, 64'h0);
        send_req(REQ_LOAD, 64'h4);
        send_req(REQ_LOAD, 64'h2);
        send_req(REQ_MODIFY, 64'h1);
        send_req(REQ_UNKNOWN, 64'hffff_ffff_ffff_ffff);
        end_burst();

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(CFG_SET_BITS, 5'(cfg_sets[ph]));
            write_reg(CFG_OFFSET_BITS, 5'(cfg_offs[ph]));
            write_reg(CFG_WAYS, 5'(cfg_ways[ph]));
            cur_set_bits = (cfg_sets[ph] > 8) ? 8 : cfg_sets[ph];
            cur_offset = cfg_offs[ph];
            n_sets = 1 << cur_set_bits;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int k = 0; k < 150; k++) begin
                if (k == 75 && ph == 2) begin
                    end_burst();
                    while (pending != 0) @(posedge i_clk);
                end
                if ($urandom_range(99) < 10) begin
                    addr = {$urandom, $urandom};
                end else begin
                    addr = make_addr(64'($urandom_range(11)),
                                     $urandom_range((n_sets > 4 ? 3 : n_sets - 1)));
                end
                send_req(pick_type(), addr);
            end
            end_burst();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[set_assoc_lru_cache_sim] OK");
        end else begin
            $display("[set_assoc_lru_cache_sim] ERROR");
        end
        $finish;
    end
endmodule
